### sv/plob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_pkg
// Types and constants shared by the price-level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int QSUM_W     = 38;
    localparam int SPREAD_W   = 33;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 240;
    localparam int OUT_USER_W = 2;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_QTY_AT = 2'd2,
        CMD_LIQ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EVICT = 2'd1,
        STAT_DROP  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_SUM_RD,
        S_SUM_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_INS_RD,
        S_INS_WR,
        S_TOP_BID,
        S_TOP_ASK,
        S_TOP_CAP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } level_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [5:0]          pad;
        logic [QSUM_W-1:0]   query_qty;
        logic [PRICE_W-1:0]  mid_point;
        logic [SPREAD_W-1:0] spread;
        logic                crossed;
        logic                ask_present;
        logic [QTY_W-1:0]    best_ask_qty;
        logic [PRICE_W-1:0]  best_ask_price;
        logic                bid_present;
        logic [QTY_W-1:0]    best_bid_qty;
        logic [PRICE_W-1:0]  best_bid_price;
    } result_t;

endpackage
`default_nettype wire

### sv/price_level_order_book_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// price_level_order_book_unit
// Two bounded sorted price-level tables (bids descending, asks ascending)
// with set / clear / exact-price query / liquidity-within-limit commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis_*: tuser carries {side, cmd}, tdata carries
//   {quantity, price}. Each command yields one result beat on m_axis_*:
//   tdata holds top of book, crossed, spread, mid and the query answer,
//   tuser holds the status code.
//   One command is processed at a time; s_axis_tready is high only while the
//   sequencer is idle. Each level visited takes a read state and a compare
//   state because the level memory has a registered read port and a single
//   comparator checks one level per visit. A set or exact-price query scans
//   the levels and then passes through a decide state; a delete or insert
//   then shifts levels with a read and a write state per shifted level. A
//   liquidity query reads and compares each level it sums. Every command then
//   reads both best levels and builds the result, and returns to idle before
//   the next accept. Clear goes straight to reading both best levels.
//   The result sits in an output register, so the next command is accepted
//   while it waits; a command that finishes while the register is still
//   full holds until the receiver takes the pending beat.
//   Reset empties both sides (level counts zero); no memory sweep is needed.
// ----------------------------------------------------------------------------
module price_level_order_book_unit #(
    parameter int LEVELS = 64
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] price, [63:32] quantity
    input  wire  [plob_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd, [2] side
    input  wire  [plob_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [31:0] best_bid_price, [63:32] best_bid_qty, [64] bid_present,
    // [96:65] best_ask_price, [128:97] best_ask_qty, [129] ask_present,
    // [130] crossed, [163:131] spread, [195:164] mid_point,
    // [233:196] query_qty, [239:234] zero
    output logic [plob_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [plob_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import plob_pkg::*;

    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);
    localparam logic [CW-1:0] LEVELS_C = CW'(LEVELS);
    localparam logic [CW-1:0] LAST_C   = CW'(LEVELS - 1);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic              side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]  qty_reg;
    logic [CW-1:0]     bid_cnt_reg, ask_cnt_reg;
    logic [CW-1:0]     i_reg, k_reg;
    logic              found_reg;
    logic [QTY_W-1:0]  hit_qty_reg;
    logic [QSUM_W-1:0] sum_reg;
    status_t           status_reg;
    level_t            top_bid_reg, top_ask_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    status_t           out_status_reg;

    level_t            book_mem [2][LEVELS];
    level_t            rd_data_reg;

    logic              s_fire, out_free;
    logic [CW-1:0]     cnt_cur, i_plus1, k_minus1;
    logic              qty_zero;

    logic              rd_en, rd_side;
    logic [IW-1:0]     rd_idx;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    level_t            wr_data;

    // shared comparator
    logic [PRICE_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;

    logic [QSUM_W:0]   sum_add;
    logic [QSUM_W-1:0] sum_next;
    result_t           res_next;
    logic              bp, ap, both;
    logic [PRICE_W:0]  mid_sum;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cnt_cur  = side_reg ? ask_cnt_reg : bid_cnt_reg;
    assign i_plus1  = i_reg + 1'b1;
    assign k_minus1 = k_reg - 1'b1;
    assign qty_zero = (qty_reg == '0);
    assign cmp_lt   = (cmp_a < cmp_b);

    assign sum_add  = {1'b0, sum_reg} + (QSUM_W + 1)'(rd_data_reg.qty);
    assign sum_next = sum_add[QSUM_W] ? {QSUM_W{1'b1}} : sum_add[QSUM_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    case (cmd_t'(s_axis_tuser[1:0]))
                        CMD_CLEAR: state_next = S_TOP_BID;
                        CMD_LIQ:   state_next = S_SUM_RD;
                        default:   state_next = S_SCAN_RD;
                    endcase
                end
            end
            S_SCAN_RD:  state_next = (i_reg == cnt_cur) ? S_DECIDE : S_SCAN_CMP;
            S_SCAN_CMP: state_next = cmp_lt ? S_SCAN_RD : S_DECIDE;
            S_DECIDE:
            begin
                if (cmd_reg != CMD_SET)
                    state_next = S_TOP_BID;
                else if (found_reg)
                    state_next = qty_zero ? S_DEL_RD : S_TOP_BID;
                else if (qty_zero)
                    state_next = S_TOP_BID;
                else if (cnt_cur == LEVELS_C && i_reg == LEVELS_C)
                    state_next = S_TOP_BID;
                else
                    state_next = S_INS_RD;
            end
            S_SUM_RD:   state_next = (i_reg == cnt_cur) ? S_TOP_BID : S_SUM_CMP;
            S_SUM_CMP:  state_next = cmp_lt ? S_TOP_BID : S_SUM_RD;
            S_DEL_RD:   state_next = (i_plus1 < cnt_cur) ? S_DEL_WR : S_TOP_BID;
            S_DEL_WR:   state_next = S_DEL_RD;
            S_INS_RD:   state_next = (k_reg == i_reg) ? S_TOP_BID : S_INS_WR;
            S_INS_WR:   state_next = S_INS_RD;
            S_TOP_BID:  state_next = S_TOP_ASK;
            S_TOP_ASK:  state_next = S_TOP_CAP;
            S_TOP_CAP:  state_next = S_RESULT;
            S_RESULT:   state_next = out_free ? S_IDLE : S_RESULT;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory port and comparator control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_side = side_reg;
        rd_idx  = i_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_idx  = i_reg[IW-1:0];
        wr_data = '{qty: qty_reg, price: price_reg};
        cmp_a   = price_reg;
        cmp_b   = rd_data_reg.price;
        case (state_reg)
            S_SCAN_RD, S_SUM_RD:
            begin
                rd_en = (i_reg != cnt_cur);
            end
            S_SCAN_CMP:
            begin
                // ranks ahead: ask price < p, bid price > p
                cmp_a = side_reg ? rd_data_reg.price : price_reg;
                cmp_b = side_reg ? price_reg : rd_data_reg.price;
            end
            S_SUM_CMP:
            begin
                // lt here means the level lies outside the limit
                cmp_a = side_reg ? price_reg : rd_data_reg.price;
                cmp_b = side_reg ? rd_data_reg.price : price_reg;
            end
            S_DECIDE:
            begin
                wr_en = (cmd_reg == CMD_SET) && found_reg && !qty_zero;
            end
            S_DEL_RD:
            begin
                rd_en  = (i_plus1 < cnt_cur);
                rd_idx = i_plus1[IW-1:0];
            end
            S_DEL_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
            end
            S_INS_RD:
            begin
                if (k_reg == i_reg)
                    wr_en = 1'b1;
                else
                begin
                    rd_en  = 1'b1;
                    rd_idx = k_minus1[IW-1:0];
                end
            end
            S_INS_WR:
            begin
                wr_en   = 1'b1;
                wr_idx  = k_reg[IW-1:0];
                wr_data = rd_data_reg;
            end
            S_TOP_BID:
            begin
                rd_en   = 1'b1;
                rd_side = SIDE_BID;
                rd_idx  = '0;
            end
            S_TOP_ASK:
            begin
                rd_en   = 1'b1;
                rd_side = SIDE_ASK;
                rd_idx  = '0;
            end
            S_RESULT:
            begin
                cmp_a = top_bid_reg.price;
                cmp_b = top_ask_reg.price;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // result assembly
    assign bp      = (bid_cnt_reg != '0);
    assign ap      = (ask_cnt_reg != '0);
    assign both    = bp && ap;
    assign mid_sum = {1'b0, top_bid_reg.price} + {1'b0, top_ask_reg.price};

    always_comb
    begin
        res_next                = '0;
        res_next.best_bid_price = bp ? top_bid_reg.price : '0;
        res_next.best_bid_qty   = bp ? top_bid_reg.qty : '0;
        res_next.bid_present    = bp;
        res_next.best_ask_price = ap ? top_ask_reg.price : '0;
        res_next.best_ask_qty   = ap ? top_ask_reg.qty : '0;
        res_next.ask_present    = ap;
        if (both)
        begin
            res_next.crossed   = !cmp_lt;
            res_next.spread    = {1'b0, top_ask_reg.price} - {1'b0, top_bid_reg.price};
            res_next.mid_point = mid_sum[PRICE_W:1];
        end
        case (cmd_reg)
            CMD_QTY_AT: res_next.query_qty = found_reg ? QSUM_W'(hit_qty_reg) : '0;
            CMD_LIQ:    res_next.query_qty = sum_reg;
            default:    res_next.query_qty = '0;
        endcase
    end

    // level memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            book_mem[side_reg][wr_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= book_mem[rd_side][rd_idx];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bid_cnt_reg   <= '0;
            ask_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_fire && cmd_t'(s_axis_tuser[1:0]) == CMD_CLEAR)
            begin
                bid_cnt_reg <= '0;
                ask_cnt_reg <= '0;
            end
            if (state_reg == S_DEL_RD && !(i_plus1 < cnt_cur))
            begin
                if (side_reg)
                    ask_cnt_reg <= cnt_cur - 1'b1;
                else
                    bid_cnt_reg <= cnt_cur - 1'b1;
            end
            // a full side keeps its count, the worst level fell off the end
            if (state_reg == S_INS_RD && k_reg == i_reg)
            begin
                if (side_reg)
                    ask_cnt_reg <= (cnt_cur == LEVELS_C) ? cnt_cur : cnt_cur + 1'b1;
                else
                    bid_cnt_reg <= (cnt_cur == LEVELS_C) ? cnt_cur : cnt_cur + 1'b1;
            end
            if (state_reg == S_RESULT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_reg    <= cmd_t'(s_axis_tuser[1:0]);
                    side_reg   <= s_axis_tuser[2];
                    price_reg  <= s_axis_tdata[PRICE_W-1:0];
                    qty_reg    <= s_axis_tdata[IN_DATA_W-1:PRICE_W];
                    i_reg      <= '0;
                    found_reg  <= 1'b0;
                    sum_reg    <= '0;
                    status_reg <= STAT_OK;
                end
            end
            S_SCAN_CMP:
            begin
                if (cmp_lt)
                    i_reg <= i_plus1;
                else
                begin
                    found_reg   <= (rd_data_reg.price == price_reg);
                    hit_qty_reg <= rd_data_reg.qty;
                end
            end
            S_DECIDE:
            begin
                if (cnt_cur == LEVELS_C)
                begin
                    k_reg <= LAST_C;
                    if (cmd_reg == CMD_SET && !found_reg && !qty_zero)
                        status_reg <= (i_reg == LEVELS_C) ? STAT_DROP : STAT_EVICT;
                end
                else
                    k_reg <= cnt_cur;
            end
            S_SUM_CMP:
            begin
                if (!cmp_lt)
                begin
                    sum_reg <= sum_next;
                    i_reg   <= i_plus1;
                end
            end
            S_DEL_WR:  i_reg <= i_plus1;
            S_INS_WR:  k_reg <= k_minus1;
            S_TOP_ASK: top_bid_reg <= rd_data_reg;
            S_TOP_CAP: top_ask_reg <= rd_data_reg;
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_data_reg   <= res_next;
                    out_status_reg <= status_reg;
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bid_cnt_reg <= LEVELS_C && ask_cnt_reg <= LEVELS_C)
        else $error("level count beyond table depth");

    a_crossed_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.crossed) |->
            (out_data_reg.bid_present && out_data_reg.ask_present))
        else $error("crossed flagged with a side empty");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser[1:0] == CMD_CLEAR) |=>
            (bid_cnt_reg == '0 && ask_cnt_reg == '0))
        else $error("clear left levels behind");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_RD && status_reg == STAT_EVICT) |-> (cnt_cur == LEVELS_C))
        else $error("eviction on a side that is not full");

    a_del_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL_WR) |-> (i_plus1 < cnt_cur))
        else $error("delete shift past last level");

endmodule
`default_nettype wire
